[sv/bfcb_pkg.sv]
// Shared types and constants of the binary frame crop bounds unit.
package bfcb_pkg;

    localparam int FRAME_ROWS_W = 9;
    localparam int FRAME_COLS_W = 10;
    localparam int THRESHOLD_W  = 9;
    localparam int CFG_DATA_W   = 10;
    localparam int CFG_INDEX_W  = 2;
    localparam int COUNT_W      = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_ROWS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COLS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD  = 2'd2;

    localparam logic [FRAME_ROWS_W-1:0] FRAME_ROWS_RESET = 9'd200;
    localparam logic [FRAME_COLS_W-1:0] FRAME_COLS_RESET = 10'd400;
    localparam logic [THRESHOLD_W-1:0]  THRESHOLD_RESET  = 9'd140;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic       frame_start;
    } pixel_in_t;

    typedef struct packed {
        logic [8:0] crop_left;
        logic [7:0] crop_top;
        logic [8:0] crop_width;
        logic [7:0] crop_height;
    } crop_out_t;

endpackage

[sv/binary_frame_crop_bounds_unit.sv]
// Top level of the binary frame crop bounds unit.
// Throughput: one pixel per cycle when not stalled; the column count memory is
// read when a pixel is accepted and written back as it leaves the second stage,
// with forwarding between them, and a frame's last pixel there registers the result.
// Input stalls only while a result is still held and the next frame's last
// pixel is ready to finish. Reset clears positions, bounds and registers to
// their defaults; the count memory is not cleared, since row 0 overwrites it.
module binary_frame_crop_bounds_unit import bfcb_pkg::*; #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 512
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  pixel_in_t              s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output crop_out_t              m_data
);

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RNW = ($clog2(MAX_ROWS + 1) > FRAME_ROWS_W) ?
                         $clog2(MAX_ROWS + 1) : FRAME_ROWS_W;
    localparam int CNW = ($clog2(MAX_COLS + 1) > FRAME_COLS_W) ?
                         $clog2(MAX_COLS + 1) : FRAME_COLS_W;

    // Configuration registers.
    logic [FRAME_ROWS_W-1:0] frame_rows_reg;
    logic [FRAME_COLS_W-1:0] frame_cols_reg;
    logic [THRESHOLD_W-1:0]  threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_rows_reg <= FRAME_ROWS_RESET;
            frame_cols_reg <= FRAME_COLS_RESET;
            threshold_reg  <= THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FRAME_ROWS: frame_rows_reg <= cfg_wdata[FRAME_ROWS_W-1:0];
                REG_FRAME_COLS: frame_cols_reg <= cfg_wdata[FRAME_COLS_W-1:0];
                REG_THRESHOLD:  threshold_reg  <= cfg_wdata[THRESHOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic [RNW-1:0] rows_raw;
    logic [RNW-1:0] rows_used;
    logic [CNW-1:0] cols_raw;
    logic [CNW-1:0] cols_used;

    assign rows_raw  = RNW'(frame_rows_reg);
    assign cols_raw  = CNW'(frame_cols_reg);
    assign rows_used = (rows_raw < RNW'(2)) ? RNW'(2) :
                       (rows_raw > RNW'(MAX_ROWS)) ? RNW'(MAX_ROWS) : rows_raw;
    assign cols_used = (cols_raw < CNW'(1)) ? CNW'(1) :
                       (cols_raw > CNW'(MAX_COLS)) ? CNW'(MAX_COLS) : cols_raw;

    // Raster position, advanced at each accepted pixel.
    logic          s_fire;
    logic          s1_stall;
    logic          s1_fire;
    logic [RW-1:0] row_pos_reg, row_pos_next;
    logic [CW-1:0] col_pos_reg, col_pos_next;
    logic [RW-1:0] cur_row;
    logic [CW-1:0] cur_col;
    logic          cur_last_col;
    logic          cur_last_row;
    logic          cur_top_half;

    assign s_ready = !s1_stall;
    assign s_fire  = s_valid && s_ready;

    assign cur_row      = s_data.frame_start ? '0 : row_pos_reg;
    assign cur_col      = s_data.frame_start ? '0 : col_pos_reg;
    assign cur_last_col = (CNW'(cur_col) + CNW'(1)) >= cols_used;
    assign cur_last_row = (RNW'(cur_row) + RNW'(1)) >= rows_used;
    assign cur_top_half = RNW'(cur_row) < (rows_used >> 1);

    always_comb begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (s_fire) begin
            if (!cur_last_col) begin
                row_pos_next = cur_row;
                col_pos_next = cur_col + CW'(1);
            end else begin
                col_pos_next = '0;
                row_pos_next = cur_last_row ? '0 : cur_row + RW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end else begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
        end
    end

    // Second stage: count update and bound tracking.
    logic          s1_valid_reg, s1_valid_next;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_row_reg;
    logic          s1_black_reg;
    logic          s1_start_reg;
    logic          s1_last_col_reg;
    logic          s1_last_row_reg;
    logic          s1_top_half_reg;
    logic [CW-1:0] s1_right_dflt_reg;
    logic [RW-1:0] s1_bottom_dflt_reg;
    logic          m_valid_reg, m_valid_next;

    assign s1_stall      = s1_valid_reg && s1_last_col_reg && s1_last_row_reg &&
                           m_valid_reg && !m_ready;
    assign s1_fire       = s1_valid_reg && !s1_stall;
    assign s1_valid_next = s_fire || s1_stall;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_col_reg         <= cur_col;
            s1_row_reg         <= cur_row;
            s1_black_reg       <= (s_data.pixel_value == 8'd0);
            s1_start_reg       <= s_data.frame_start;
            s1_last_col_reg    <= cur_last_col;
            s1_last_row_reg    <= cur_last_row;
            s1_top_half_reg    <= cur_top_half;
            s1_right_dflt_reg  <= CW'(cols_used - CNW'(1));
            s1_bottom_dflt_reg <= RW'(rows_used - RNW'(1));
        end
    end

    logic [COUNT_W-1:0] col_count;

    bfcb_col_count #(
        .DEPTH  (MAX_COLS),
        .ADDR_W (CW)
    ) u_col_count (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_fire),
        .rd_addr  (cur_col),
        .wr_en    (s1_fire),
        .wr_addr  (s1_col_reg),
        .row_zero (s1_row_reg == '0),
        .black    (s1_black_reg),
        .count    (col_count)
    );

    // Bound state.
    logic          row_white_reg,    row_white_next;
    logic [RW-1:0] top_row_reg,      top_row_next;
    logic          top_found_reg,    top_found_next;
    logic [RW-1:0] bottom_row_reg,   bottom_row_next;
    logic          bottom_found_reg, bottom_found_next;
    logic [CW-1:0] left_col_reg,     left_col_next;
    logic [CW-1:0] right_col_reg,    right_col_next;
    logic          dark_found_reg,   dark_found_next;

    logic          frame_done;
    logic          dark_hit;
    logic [CW-1:0] left_sel;
    logic [CW-1:0] right_sel;
    logic [RW-1:0] top_sel;
    logic [RW-1:0] bottom_sel;
    crop_out_t     result;

    assign frame_done = s1_last_col_reg && s1_last_row_reg;
    assign dark_hit   = s1_last_row_reg && (col_count > threshold_reg);

    always_comb begin
        row_white_next    = row_white_reg;
        top_row_next      = top_row_reg;
        top_found_next    = top_found_reg;
        bottom_row_next   = bottom_row_reg;
        bottom_found_next = bottom_found_reg;
        left_col_next     = left_col_reg;
        right_col_next    = right_col_reg;
        dark_found_next   = dark_found_reg;

        // A frame start drops whatever was found in the partial frame.
        if (s1_start_reg) begin
            row_white_next    = 1'b0;
            top_row_next      = '0;
            top_found_next    = 1'b0;
            bottom_row_next   = '0;
            bottom_found_next = 1'b0;
            left_col_next     = '0;
            right_col_next    = '0;
            dark_found_next   = 1'b0;
        end

        if (dark_hit) begin
            if (!dark_found_next) begin
                left_col_next = s1_col_reg;
            end
            right_col_next  = s1_col_reg;
            dark_found_next = 1'b1;
        end

        if (!s1_black_reg) begin
            row_white_next = 1'b1;
        end

        if (s1_last_col_reg) begin
            if (!row_white_next) begin
                if (s1_top_half_reg) begin
                    if (!top_found_next) begin
                        top_row_next   = s1_row_reg;
                        top_found_next = 1'b1;
                    end
                end else if (!bottom_found_next) begin
                    bottom_row_next   = s1_row_reg;
                    bottom_found_next = 1'b1;
                end
            end
            row_white_next = 1'b0;
        end

        left_sel   = dark_found_next   ? left_col_next   : '0;
        right_sel  = dark_found_next   ? right_col_next  : s1_right_dflt_reg;
        top_sel    = top_found_next    ? top_row_next    : '0;
        bottom_sel = bottom_found_next ? bottom_row_next : s1_bottom_dflt_reg;

        result.crop_left   = 9'(left_sel);
        result.crop_top    = 8'(top_sel);
        result.crop_width  = (right_sel >= left_sel) ? 9'(right_sel - left_sel) : 9'd0;
        result.crop_height = (bottom_sel >= top_sel) ? 8'(bottom_sel - top_sel) : 8'd0;

        if (frame_done) begin
            row_white_next    = 1'b0;
            top_row_next      = '0;
            top_found_next    = 1'b0;
            bottom_row_next   = '0;
            bottom_found_next = 1'b0;
            left_col_next     = '0;
            right_col_next    = '0;
            dark_found_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_white_reg    <= 1'b0;
            top_row_reg      <= '0;
            top_found_reg    <= 1'b0;
            bottom_row_reg   <= '0;
            bottom_found_reg <= 1'b0;
            left_col_reg     <= '0;
            right_col_reg    <= '0;
            dark_found_reg   <= 1'b0;
        end else if (s1_fire) begin
            row_white_reg    <= row_white_next;
            top_row_reg      <= top_row_next;
            top_found_reg    <= top_found_next;
            bottom_row_reg   <= bottom_row_next;
            bottom_found_reg <= bottom_found_next;
            left_col_reg     <= left_col_next;
            right_col_reg    <= right_col_next;
            dark_found_reg   <= dark_found_next;
        end
    end

    // Output register.
    crop_out_t m_data_reg;
    logic      m_load;

    assign m_load       = s1_fire && frame_done;
    assign m_valid_next = m_load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[sv/bfcb_col_count.sv]
// Per-column black pixel count memory with read-modify-write and forwarding.
module bfcb_col_count import bfcb_pkg::*; #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic               row_zero,
    input  logic               black,
    output logic [COUNT_W-1:0] count
);

    logic [COUNT_W-1:0] count_mem [DEPTH];
    logic [COUNT_W-1:0] rd_data_reg;
    logic               fwd_hit_reg;
    logic               fwd_hit_next;
    logic [COUNT_W-1:0] fwd_data_reg;
    logic [COUNT_W-1:0] count_old;
    logic [COUNT_W-1:0] count_base;

    // The memory returns the old word when the entry is written in the same
    // cycle, so a read that meets the write of the previous pixel takes the
    // written value from the forwarding register instead.
    assign fwd_hit_next = wr_en && (rd_addr == wr_addr);

    assign count_old  = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign count_base = row_zero ? '0 : count_old;
    assign count      = (black && (count_base != COUNT_MAX)) ?
                        count_base + COUNT_W'(1) : count_base;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= count_mem[rd_addr];
            fwd_data_reg <= count;
        end
        if (wr_en) begin
            count_mem[wr_addr] <= count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_hit_reg <= fwd_hit_next;
        end
    end

endmodule
